// ===== hw/rtl/btd_pkg.sv =====
// Shared types, codes and month tables for the BCD time/date command decoder.
package btd_pkg;

    typedef enum logic [1:0] {
        KIND_ALARM = 2'd0,
        KIND_DATE  = 2'd1,
        KIND_TIME  = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    localparam logic [7:0] REPLY_OK  = 8'h55;
    localparam logic [7:0] REPLY_BAD = 8'hAA;
    localparam logic [7:0] REPLY_NONE = 8'h00;

    localparam logic [14:0] YEAR_MIN = 15'd1900;
    localparam logic [14:0] YEAR_MAX = 15'd2100;

    // Decoded message after the BCD stage.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
    } s1_t;

    // Year assembled, field checks and month table lookups done.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [14:0] year;
        logic        time_ok;
        logic        sec_ok;
        logic        month_ok;
        logic        jan_feb;
        logic [4:0]  mlen;
        logic [8:0]  dbefore;
        logic [4:0]  mterm;
    } s2_t;

    // Final fields, with the weekday sum still to be reduced modulo seven.
    typedef struct packed {
        kind_t       kind;
        logic        accepted;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [14:0] year;
        logic [11:0] wsum;
        logic [8:0]  yday;
    } s3_t;

    function automatic logic [7:0] bcd_dec(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0000, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd2:    r = 5'd28;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // (31 * M) / 12 where M counts months from March, with January and
    // February as months 11 and 12 of the previous year.
    function automatic logic [4:0] month_term(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd1:    r = 5'd28;
            4'd2:    r = 5'd31;
            4'd3:    r = 5'd2;
            4'd4:    r = 5'd5;
            4'd5:    r = 5'd7;
            4'd6:    r = 5'd10;
            4'd7:    r = 5'd12;
            4'd8:    r = 5'd15;
            4'd9:    r = 5'd18;
            4'd10:   r = 5'd20;
            4'd11:   r = 5'd23;
            4'd12:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/btd_decode.sv =====
// Stage one: BCD decode of the four message bytes.
module btd_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       msg_type,
    input  logic [7:0]       bcd_byte1,
    input  logic [7:0]       bcd_byte2,
    input  logic [7:0]       bcd_byte3,
    input  logic [7:0]       bcd_byte4,
    output logic             out_valid,
    output btd_pkg::s1_t     out_data
);

    logic         valid_reg;
    btd_pkg::s1_t data_reg;
    btd_pkg::s1_t data_next;

    always_comb
    begin
        data_next.kind = btd_pkg::kind_t'(msg_type);
        data_next.b1   = btd_pkg::bcd_dec(bcd_byte1);
        data_next.b2   = btd_pkg::bcd_dec(bcd_byte2);
        data_next.b3   = btd_pkg::bcd_dec(bcd_byte3);
        data_next.b4   = btd_pkg::bcd_dec(bcd_byte4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/btd_prep.sv =====
// Stage two: year assembly, time field checks and month table lookups.
module btd_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  btd_pkg::s1_t     in_data,
    output logic             out_valid,
    output btd_pkg::s2_t     out_data
);

    logic         valid_reg;
    btd_pkg::s2_t data_reg;
    btd_pkg::s2_t data_next;

    always_comb
    begin
        data_next.kind     = in_data.kind;
        data_next.b1       = in_data.b1;
        data_next.b2       = in_data.b2;
        data_next.b3       = in_data.b3;
        data_next.year     = 15'(in_data.b3) * 15'd100 + 15'(in_data.b4);
        data_next.time_ok  = (in_data.b1 < 8'd24) && (in_data.b2 < 8'd60);
        data_next.sec_ok   = in_data.b3 < 8'd60;
        data_next.month_ok = (in_data.b2 >= 8'd1) && (in_data.b2 <= 8'd12);
        data_next.jan_feb  = in_data.b2 <= 8'd2;
        data_next.mlen     = btd_pkg::month_len(in_data.b2[3:0]);
        data_next.dbefore  = btd_pkg::days_before(in_data.b2[3:0]);
        data_next.mterm    = btd_pkg::month_term(in_data.b2[3:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/btd_calc.sv =====
// Stage three: date validation, weekday sum, day of year and field selection.
module btd_calc (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  btd_pkg::s2_t     in_data,
    output logic             out_valid,
    output btd_pkg::s3_t     out_data
);

    logic         valid_reg;
    btd_pkg::s3_t data_reg;
    btd_pkg::s3_t data_next;

    logic        year_ok;
    logic        leap;
    logic [4:0]  len;
    logic        date_ok;
    logic [11:0] y;
    logic [4:0]  c100;
    logic [2:0]  c400;
    logic [11:0] wsum;
    logic [8:0]  yday;

    always_comb
    begin
        year_ok = (in_data.year >= btd_pkg::YEAR_MIN) && (in_data.year <= btd_pkg::YEAR_MAX);
        // Of the century years inside the range, only 2000 is a leap year here.
        leap    = (in_data.year[1:0] == 2'b00) && (in_data.year != btd_pkg::YEAR_MIN)
                  && (in_data.year != btd_pkg::YEAR_MAX);
        len     = (in_data.b2 == 8'd2 && leap) ? 5'd29 : in_data.mlen;
        date_ok = year_ok && in_data.month_ok && (in_data.b1 >= 8'd1)
                  && (in_data.b1 <= {3'b000, len});

        // For a valid date y lies in 1899..2100, so the century quotients
        // reduce to a few compares.
        y = in_data.year[11:0] - {11'b0, in_data.jan_feb};
        if (y >= 12'd2100)
        begin
            c100 = 5'd21;
        end
        else if (y >= 12'd2000)
        begin
            c100 = 5'd20;
        end
        else if (y >= 12'd1900)
        begin
            c100 = 5'd19;
        end
        else
        begin
            c100 = 5'd18;
        end
        c400 = (y >= 12'd2000) ? 3'd5 : 3'd4;

        wsum = {4'b0000, in_data.b1} + y + (y >> 2) + {9'b0, c400}
               + {7'b0, in_data.mterm} - {7'b0, c100};
        yday = in_data.dbefore + {1'b0, in_data.b1} - 9'd1
               + {8'b0, (leap && in_data.b2 > 8'd2)};

        data_next.kind     = in_data.kind;
        data_next.accepted = 1'b0;
        data_next.hour     = 8'd0;
        data_next.minute   = 8'd0;
        data_next.second   = 8'd0;
        data_next.day      = 8'd0;
        data_next.month    = 8'd0;
        data_next.year     = 15'd0;
        data_next.wsum     = 12'd0;
        data_next.yday     = 9'd0;
        case (in_data.kind)
            btd_pkg::KIND_ALARM:
            begin
                data_next.accepted = in_data.time_ok;
                data_next.hour     = in_data.b1;
                data_next.minute   = in_data.b2;
            end
            btd_pkg::KIND_TIME:
            begin
                data_next.accepted = in_data.time_ok && in_data.sec_ok;
                data_next.hour     = in_data.b1;
                data_next.minute   = in_data.b2;
                data_next.second   = in_data.b3;
            end
            btd_pkg::KIND_DATE:
            begin
                data_next.accepted = date_ok;
                data_next.day      = in_data.b1;
                data_next.month    = in_data.b2;
                data_next.year     = in_data.year;
                data_next.wsum     = date_ok ? wsum : 12'd0;
                data_next.yday     = date_ok ? yday : 9'd0;
            end
            default:
            begin
                data_next.accepted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/btd_out.sv =====
// Stage four: weekday modulo reduction, reply code and the result registers.
module btd_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  btd_pkg::s3_t     in_data,
    output logic             done,
    output logic [1:0]       kind,
    output logic             accepted,
    output logic [7:0]       hour,
    output logic [7:0]       minute,
    output logic [7:0]       second,
    output logic [7:0]       day_of_month,
    output logic [7:0]       month_number,
    output logic [14:0]      full_year,
    output logic [2:0]       week_day,
    output logic [8:0]       day_of_year,
    output logic [7:0]       reply_byte
);

    logic         done_reg;
    btd_pkg::s3_t data_reg;
    logic [2:0]   wday_reg;
    logic [2:0]   wday_next;
    logic [7:0]   reply_reg;
    logic [7:0]   reply_next;

    logic [4:0]   fold1;
    logic [3:0]   fold2;

    always_comb
    begin
        // Eight is one modulo seven, so octal digits can be summed.
        fold1 = {2'b00, in_data.wsum[2:0]} + {2'b00, in_data.wsum[5:3]}
                + {2'b00, in_data.wsum[8:6]} + {2'b00, in_data.wsum[11:9]};
        fold2 = {1'b0, fold1[2:0]} + {2'b00, fold1[4:3]};
        wday_next = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

        if (in_data.kind == btd_pkg::KIND_OTHER)
        begin
            reply_next = btd_pkg::REPLY_NONE;
        end
        else if (in_data.accepted)
        begin
            reply_next = btd_pkg::REPLY_OK;
        end
        else
        begin
            reply_next = btd_pkg::REPLY_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg  <= in_data;
            wday_reg  <= wday_next;
            reply_reg <= reply_next;
        end
    end

    assign done         = done_reg;
    assign kind         = data_reg.kind;
    assign accepted     = data_reg.accepted;
    assign hour         = data_reg.hour;
    assign minute       = data_reg.minute;
    assign second       = data_reg.second;
    assign day_of_month = data_reg.day;
    assign month_number = data_reg.month;
    assign full_year    = data_reg.year;
    assign week_day     = wday_reg;
    assign day_of_year  = data_reg.yday;
    assign reply_byte   = reply_reg;

endmodule

// ===== hw/rtl/bcd_time_date_command_decoder_top.sv =====
// Top level of the BCD time/date command decoder: four-stage pipeline.
//
//  Channel   Handshake       Payload
//  --------  --------------  ---------------------------------------------------
//  command   start / busy    msg_type, bcd_byte1..bcd_byte4
//  result    done (strobe)   kind, accepted, hour, minute, second, day_of_month,
//                            month_number, full_year, week_day, day_of_year,
//                            reply_byte
//
// A command transfer completes on any edge with start high; busy is always low.
// Each result passes the decode, prep, calc and out registers in turn and is shown for one cycle under done.
// One command can be taken every cycle; the four stages set the latency.
// Reset clears only the stage valid bits; results are never held off.
module bcd_time_date_command_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  msg_type,
    input  logic [7:0]  bcd_byte1,
    input  logic [7:0]  bcd_byte2,
    input  logic [7:0]  bcd_byte3,
    input  logic [7:0]  bcd_byte4,
    output logic        done,
    output logic [1:0]  kind,
    output logic        accepted,
    output logic [7:0]  hour,
    output logic [7:0]  minute,
    output logic [7:0]  second,
    output logic [7:0]  day_of_month,
    output logic [7:0]  month_number,
    output logic [14:0] full_year,
    output logic [2:0]  week_day,
    output logic [8:0]  day_of_year,
    output logic [7:0]  reply_byte
);

    logic         s1_valid;
    btd_pkg::s1_t s1_data;
    logic         s2_valid;
    btd_pkg::s2_t s2_data;
    logic         s3_valid;
    btd_pkg::s3_t s3_data;
    logic         take;

    assign busy = 1'b0;
    assign take = start && !busy;

    btd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (take),
        .msg_type  (msg_type),
        .bcd_byte1 (bcd_byte1),
        .bcd_byte2 (bcd_byte2),
        .bcd_byte3 (bcd_byte3),
        .bcd_byte4 (bcd_byte4),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    btd_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_data  (s2_data)
    );

    btd_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_data  (s3_data)
    );

    btd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s3_valid),
        .in_data      (s3_data),
        .done         (done),
        .kind         (kind),
        .accepted     (accepted),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .day_of_month (day_of_month),
        .month_number (month_number),
        .full_year    (full_year),
        .week_day     (week_day),
        .day_of_year  (day_of_year),
        .reply_byte   (reply_byte)
    );

    // Every command transfer comes out as exactly one result from the last stage register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##4 done)
        else $error("command transfer produced no result");

    a_reply_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && accepted |-> reply_byte == btd_pkg::REPLY_OK)
        else $error("accepted result without OK reply");

    a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        done && kind == btd_pkg::KIND_OTHER |->
            !accepted && reply_byte == btd_pkg::REPLY_NONE && full_year == 15'd0)
        else $error("ignored command produced a non-empty result");

    a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !accepted |-> week_day == 3'd0 && day_of_year == 9'd0)
        else $error("rejected command carries weekday or day of year");

endmodule

// ===== tb/btd_result_monitor.sv =====
// Result monitor for the BCD time/date command decoder: predicts every decode and checks it.
`timescale 1ns / 100ps

module btd_result_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  msg_type,
    input  logic [7:0]  bcd_byte1,
    input  logic [7:0]  bcd_byte2,
    input  logic [7:0]  bcd_byte3,
    input  logic [7:0]  bcd_byte4,
    input  logic        done,
    input  logic [1:0]  kind,
    input  logic        accepted,
    input  logic [7:0]  hour,
    input  logic [7:0]  minute,
    input  logic [7:0]  second,
    input  logic [7:0]  day_of_month,
    input  logic [7:0]  month_number,
    input  logic [14:0] full_year,
    input  logic [2:0]  week_day,
    input  logic [8:0]  day_of_year,
    input  logic [7:0]  reply_byte,
    output int          failures,
    output int          outstanding
);

    typedef struct packed {
        btd_pkg::kind_t kind;
        logic        accepted;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [7:0]  day_of_month;
        logic [7:0]  month_number;
        logic [14:0] full_year;
        logic [2:0]  week_day;
        logic [8:0]  day_of_year;
        logic [7:0]  reply_byte;
    } decode_t;

    decode_t decode_q[$];
    decode_t want;

    initial
    begin
        failures = 0;
        outstanding = 0;
    end

    // Nibbles are weighted 10 and 1 with no check for digits above nine.
    function automatic int bcd_value(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && (y != 1900) && (y != 2100);
    endfunction

    function automatic int month_days(input int m, input int y);
        int n;
        case (m)
            2:       n = leap_year(y) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default: n = 31;
        endcase
        return n;
    endfunction

    function automatic decode_t decode_command(input btd_pkg::kind_t t,
                                               input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3,
                                               input logic [7:0] b4);
        decode_t r;
        int d1;
        int d2;
        int d3;
        int yr;
        int a;
        int y;
        int mm;
        int yd;
        r = '0;
        d1 = bcd_value(b1);
        d2 = bcd_value(b2);
        d3 = bcd_value(b3);
        yr = d3 * 100 + bcd_value(b4);
        r.kind = t;
        case (t)
            btd_pkg::KIND_ALARM:
            begin
                r.hour = 8'(d1);
                r.minute = 8'(d2);
                r.accepted = (d1 < 24) && (d2 < 60);
            end
            btd_pkg::KIND_TIME:
            begin
                r.hour = 8'(d1);
                r.minute = 8'(d2);
                r.second = 8'(d3);
                r.accepted = (d1 < 24) && (d2 < 60) && (d3 < 60);
            end
            btd_pkg::KIND_DATE:
            begin
                r.day_of_month = 8'(d1);
                r.month_number = 8'(d2);
                r.full_year = 15'(yr);
                if (yr >= 1900 && yr <= 2100 && d2 >= 1 && d2 <= 12 &&
                    d1 >= 1 && d1 <= month_days(d2, yr))
                begin
                    r.accepted = 1'b1;
                    // January and February count as months 11 and 12 of the year before.
                    a = (14 - d2) / 12;
                    y = yr - a;
                    mm = d2 + 12 * a - 2;
                    r.week_day = 3'((d1 + y + y / 4 - y / 100 + y / 400 + (31 * mm) / 12) % 7);
                    yd = d1 - 1;
                    for (int m = 1; m < d2; m++)
                        yd += month_days(m, yr);
                    r.day_of_year = 9'(yd);
                end
            end
            default:
            begin
            end
        endcase
        if (t == btd_pkg::KIND_OTHER)
            r.reply_byte = btd_pkg::REPLY_NONE;
        else
            r.reply_byte = r.accepted ? btd_pkg::REPLY_OK : btd_pkg::REPLY_BAD;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: ERROR %s", $time, msg);
        failures++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_v);
        if (got != exp_v)
            report_mismatch($sformatf("%s is %0d, predicted %0d (kind %0d)",
                                      name, got, exp_v, want.kind));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (decode_q.size() == 0)
                    report_mismatch("result strobe with no command transfer outstanding");
                else
                begin
                    want = decode_q.pop_front();
                    check_field("kind", kind, want.kind);
                    check_field("accepted", accepted, want.accepted);
                    check_field("hour", hour, want.hour);
                    check_field("minute", minute, want.minute);
                    check_field("second", second, want.second);
                    check_field("day_of_month", day_of_month, want.day_of_month);
                    check_field("month_number", month_number, want.month_number);
                    check_field("full_year", full_year, want.full_year);
                    check_field("week_day", week_day, want.week_day);
                    check_field("day_of_year", day_of_year, want.day_of_year);
                    check_field("reply_byte", reply_byte, want.reply_byte);
                end
            end
            if (start && !busy)
                decode_q.push_back(decode_command(btd_pkg::kind_t'(msg_type), bcd_byte1,
                                                  bcd_byte2, bcd_byte3, bcd_byte4));
            outstanding <= decode_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the BCD time/date command decoder: clock, reset, command stimulus, verdict.
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_COMMANDS = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  msg_type;
    logic [7:0]  bcd_byte1;
    logic [7:0]  bcd_byte2;
    logic [7:0]  bcd_byte3;
    logic [7:0]  bcd_byte4;
    logic        done;
    logic [1:0]  kind;
    logic        accepted;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [7:0]  day_of_month;
    logic [7:0]  month_number;
    logic [14:0] full_year;
    logic [2:0]  week_day;
    logic [8:0]  day_of_year;
    logic [7:0]  reply_byte;
    int          failures;
    int          outstanding;
    int          cycle_count;
    bit          steady;

    bcd_time_date_command_decoder_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .msg_type(msg_type),
        .bcd_byte1(bcd_byte1), .bcd_byte2(bcd_byte2), .bcd_byte3(bcd_byte3),
        .bcd_byte4(bcd_byte4), .done(done), .kind(kind), .accepted(accepted),
        .hour(hour), .minute(minute), .second(second), .day_of_month(day_of_month),
        .month_number(month_number), .full_year(full_year), .week_day(week_day),
        .day_of_year(day_of_year), .reply_byte(reply_byte)
    );

    btd_result_monitor result_monitor (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .msg_type(msg_type),
        .bcd_byte1(bcd_byte1), .bcd_byte2(bcd_byte2), .bcd_byte3(bcd_byte3),
        .bcd_byte4(bcd_byte4), .done(done), .kind(kind), .accepted(accepted),
        .hour(hour), .minute(minute), .second(second), .day_of_month(day_of_month),
        .month_number(month_number), .full_year(full_year), .week_day(week_day),
        .day_of_year(day_of_year), .reply_byte(reply_byte),
        .failures(failures), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bcd_time_date_command_decoder_top: mismatch");
            $finish;
        end
    end

    function automatic logic [7:0] to_bcd(input int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // Called at a rising edge; returns at the edge on which the transfer completes.
    task automatic send_command(input btd_pkg::kind_t t, input logic [7:0] b1,
                                input logic [7:0] b2,
                                input logic [7:0] b3, input logic [7:0] b4);
        int gap;
        bit was_busy;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        msg_type <= t;
        bcd_byte1 <= b1;
        bcd_byte2 <= b2;
        bcd_byte3 <= b3;
        bcd_byte4 <= b4;
        forever
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
            if (!was_busy)
                break;
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic send_random_command();
        int pick;
        int century;
        int low;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            send_command(btd_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
        else if (pick < 40)
        begin
            // Mostly legal calendar dates, with the century edges well represented.
            century = $urandom_range(18, 21);
            low = (century == 21 || century == 18) ? $urandom_range(0, 2) + 97 * (century == 18)
                                                   : $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                send_command(btd_pkg::KIND_DATE, to_bcd($urandom_range(0, 99)),
                             to_bcd($urandom_range(0, 15)), to_bcd(century), to_bcd(low));
            else
                send_command(btd_pkg::KIND_DATE, to_bcd($urandom_range(1, 31)),
                             to_bcd($urandom_range(1, 12)), to_bcd(century), to_bcd(low));
        end
        else if (pick < 65)
            send_command(btd_pkg::KIND_TIME, to_bcd($urandom_range(0, 25)),
                         to_bcd($urandom_range(0, 61)), to_bcd($urandom_range(0, 61)),
                         8'($urandom));
        else if (pick < 88)
            send_command(btd_pkg::KIND_ALARM, to_bcd($urandom_range(0, 25)),
                         to_bcd($urandom_range(0, 61)), 8'($urandom), 8'($urandom));
        else
            send_command(btd_pkg::KIND_OTHER, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
    endtask

    initial
    begin
        cycle_count = 0;
        steady = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        msg_type = '0;
        bcd_byte1 = '0;
        bcd_byte2 = '0;
        bcd_byte3 = '0;
        bcd_byte4 = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Boundaries of every check, back to back.
        send_command(btd_pkg::KIND_ALARM, 8'h00, 8'h00, 8'hFF, 8'hFF);
        send_command(btd_pkg::KIND_ALARM, 8'h23, 8'h59, 8'h99, 8'h00);
        send_command(btd_pkg::KIND_ALARM, 8'h24, 8'h00, 8'h00, 8'h00);
        send_command(btd_pkg::KIND_ALARM, 8'h23, 8'h60, 8'h00, 8'h00);
        send_command(btd_pkg::KIND_TIME, 8'h23, 8'h59, 8'h59, 8'hFF);
        send_command(btd_pkg::KIND_TIME, 8'h23, 8'h59, 8'h60, 8'h00);
        send_command(btd_pkg::KIND_TIME, 8'h0F, 8'h3F, 8'h1F, 8'h00);
        send_command(btd_pkg::KIND_TIME, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_command(btd_pkg::KIND_DATE, 8'h01, 8'h01, 8'h19, 8'h00);
        send_command(btd_pkg::KIND_DATE, 8'h31, 8'h12, 8'h21, 8'h00);
        send_command(btd_pkg::KIND_DATE, 8'h31, 8'h12, 8'h18, 8'h99);
        send_command(btd_pkg::KIND_DATE, 8'h01, 8'h01, 8'h21, 8'h01);
        send_command(btd_pkg::KIND_DATE, 8'h29, 8'h02, 8'h20, 8'h00);
        send_command(btd_pkg::KIND_DATE, 8'h29, 8'h02, 8'h19, 8'h00);
        send_command(btd_pkg::KIND_DATE, 8'h29, 8'h02, 8'h21, 8'h00);
        send_command(btd_pkg::KIND_DATE, 8'h29, 8'h02, 8'h20, 8'h04);
        send_command(btd_pkg::KIND_DATE, 8'h29, 8'h02, 8'h20, 8'h01);
        send_command(btd_pkg::KIND_DATE, 8'h31, 8'h12, 8'h20, 8'h04);
        send_command(btd_pkg::KIND_DATE, 8'h15, 8'h00, 8'h20, 8'h24);
        send_command(btd_pkg::KIND_DATE, 8'h15, 8'h13, 8'h20, 8'h24);
        send_command(btd_pkg::KIND_DATE, 8'h00, 8'h04, 8'h20, 8'h24);
        send_command(btd_pkg::KIND_DATE, 8'h31, 8'h04, 8'h20, 8'h24);
        send_command(btd_pkg::KIND_DATE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_command(btd_pkg::KIND_OTHER, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_command(btd_pkg::KIND_OTHER, 8'h00, 8'h00, 8'h00, 8'h00);

        for (int i = 0; i < RANDOM_COMMANDS; i++)
        begin
            // Stretches with no idle cycles alternate with randomly gapped ones.
            steady = ((i / 40) % 3) == 0;
            if (i == RANDOM_COMMANDS / 2)
                drain_results();
            send_random_command();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("bcd_time_date_command_decoder_top: match");
        else
            $display("bcd_time_date_command_decoder_top: mismatch");
        $finish;
    end

endmodule
